### hw/rtl/ptrs_pkg.sv
// Shared types and constants for the periodic task release scheduler.
// Holds the beat structs, the slot command passed along the cell chain
// and the control state enum. No dependencies.
package ptrs_pkg;

  localparam int PTRS_NUM_SLOTS  = 8;
  localparam int PTRS_TIME_WIDTH = 32;

  // Input item kinds. Code 3 carries no meaning and is ignored.
  localparam logic [1:0] KIND_ATTACH = 2'd0;
  localparam logic [1:0] KIND_TICK   = 2'd1;
  localparam logic [1:0] KIND_MSG    = 2'd2;

  typedef struct packed {
    logic [1:0]  kind;
    logic [7:0]  task_id;
    logic [31:0] interval;
    logic        one_shot;
    logic [7:0]  msg_source;
    logic [7:0]  msg_destination;
    logic        msg_to_task;
    logic [31:0] msg_data;
  } ptrs_in_t;

  typedef struct packed {
    logic [7:0] release_mask;
    logic       attach_error;
    logic [3:0] slots_used;
  } ptrs_out_t;

  typedef enum logic [1:0] {
    OP_NONE,
    OP_ATTACH,
    OP_TICK,
    OP_MSG
  } ptrs_op_t;

  // Command that walks the slot chain. For OP_MSG, task_id holds the
  // destination and interval holds the new interval.
  typedef struct packed {
    logic        valid;
    ptrs_op_t    op;
    logic [7:0]  task_id;
    logic [31:0] interval;
    logic        one_shot;
  } ptrs_cmd_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RUN,
    ST_HOLD
  } ptrs_state_t;

endpackage

### hw/rtl/ptrs_cell.sv
// One slot of the scheduler table, a link of the slot chain.
// Depends on ptrs_pkg for the command struct.
module ptrs_cell #(
  parameter int NUM_SLOTS  = ptrs_pkg::PTRS_NUM_SLOTS,
  parameter int TIME_WIDTH = ptrs_pkg::PTRS_TIME_WIDTH,
  parameter int IDX        = 0
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  ptrs_pkg::ptrs_cmd_t              cmd_i,
  input  logic [TIME_WIDTH-1:0]            time_i,
  input  logic [$clog2(NUM_SLOTS+1)-1:0]   used_i,
  input  logic [NUM_SLOTS-1:0]             mask_i,
  output ptrs_pkg::ptrs_cmd_t              cmd_o,
  output logic [TIME_WIDTH-1:0]            time_o,
  output logic [$clog2(NUM_SLOTS+1)-1:0]   used_o,
  output logic [NUM_SLOTS-1:0]             mask_o
);
  import ptrs_pkg::*;

  localparam int UW = $clog2(NUM_SLOTS + 1);
  localparam int CW = (TIME_WIDTH > 32) ? TIME_WIDTH : 32;

  logic [7:0]            task_r;
  logic [31:0]           interval_r, interval_nxt;
  logic [TIME_WIDTH-1:0] last_r, last_nxt;
  logic [TIME_WIDTH-1:0] seen_r, seen_nxt;
  logic                  one_shot_r, one_shot_nxt;
  logic                  done_r, done_nxt;

  ptrs_cmd_t             cmd_r;
  logic [TIME_WIDTH-1:0] time_r;
  logic [UW-1:0]         used_r;
  logic [NUM_SLOTS-1:0]  mask_r, mask_nxt;

  logic                  attached;
  logic                  is_target;
  logic [TIME_WIDTH-1:0] diff;
  logic                  fire;

  assign attached  = UW'(IDX) < used_i;
  assign is_target = UW'(IDX) == used_i;
  assign diff      = time_i - last_r;

  always_comb begin
    interval_nxt = interval_r;
    last_nxt     = last_r;
    seen_nxt     = seen_r;
    one_shot_nxt = one_shot_r;
    done_nxt     = done_r;
    fire         = 1'b0;
    if (cmd_i.valid) begin
      case (cmd_i.op)
        OP_ATTACH: begin
          if (is_target) begin
            interval_nxt = cmd_i.interval;
            one_shot_nxt = cmd_i.one_shot;
            last_nxt     = '0;
            done_nxt     = 1'b0;
          end
        end
        OP_TICK: begin
          if (attached) begin
            if (interval_r == 32'd0) begin
              fire = 1'b1;
            end else begin
              seen_nxt = time_i;
              // The interval is compared at full width, so one that does
              // not fit in the counter never matches.
              if (CW'(diff) == CW'(interval_r)) begin
                last_nxt = time_i;
                fire     = 1'b1;
              end
            end
            if (fire && one_shot_r) begin
              if (done_r) begin
                fire = 1'b0;
              end else begin
                done_nxt = 1'b1;
              end
            end
          end
        end
        OP_MSG: begin
          if (attached && task_r == cmd_i.task_id) begin
            interval_nxt = cmd_i.interval;
            last_nxt     = seen_r;
          end
        end
        default: ;
      endcase
    end
    mask_nxt      = mask_i;
    mask_nxt[IDX] = mask_i[IDX] | fire;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      last_r      <= '0;
      seen_r      <= '0;
      one_shot_r  <= 1'b0;
      done_r      <= 1'b0;
      cmd_r       <= '0;
    end else begin
      last_r      <= last_nxt;
      seen_r      <= seen_nxt;
      one_shot_r  <= one_shot_nxt;
      done_r      <= done_nxt;
      cmd_r       <= cmd_i;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd_i.valid && cmd_i.op == OP_ATTACH && is_target) begin
      task_r <= cmd_i.task_id;
    end
    interval_r   <= interval_nxt;
    time_r <= time_i;
    used_r <= used_i;
    mask_r <= mask_nxt;
  end

  assign cmd_o  = cmd_r;
  assign time_o = time_r;
  assign used_o = used_r;
  assign mask_o = mask_r;

  // A slot can only be marked done if it was attached as one-shot.
  a_done_one_shot: assert property (@(posedge clk) disable iff (!rst_n)
    done_r |-> one_shot_r)
    else $error("slot %0d done without one-shot", IDX);

  a_attach_room: assert property (@(posedge clk) disable iff (!rst_n)
    cmd_i.valid && cmd_i.op == OP_ATTACH |-> used_i < UW'(NUM_SLOTS))
    else $error("slot %0d saw an attach to a full table", IDX);

  a_quiet_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !cmd_i.valid |=> $stable(last_r) && $stable(done_r))
    else $error("slot %0d changed timing without a command", IDX);

endmodule

### hw/rtl/periodic_task_release_scheduler.sv
// Top level of the periodic task release scheduler: control, counters and
// the chain of slot cells. Depends on ptrs_pkg and ptrs_cell.
//
// Each input beat is accepted only while the block is idle; no new beat is
// taken until its result has been moved into the output register. The beat
// is decoded into the launch register, walks the cell chain through one
// register per slot, and its result is collected and then moved into the
// output register once that register is free. A finished result may wait
// in the output register while the next beat is taken. Attach beats fill
// slots in order; tick beats advance the counter and report the slots
// released; scheduler messages retime the slots of the addressed task.
module periodic_task_release_scheduler #(
  parameter int NUM_SLOTS  = ptrs_pkg::PTRS_NUM_SLOTS,
  parameter int TIME_WIDTH = ptrs_pkg::PTRS_TIME_WIDTH
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  ptrs_pkg::ptrs_in_t  in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output ptrs_pkg::ptrs_out_t out_data
);
  import ptrs_pkg::*;

  localparam int UW = $clog2(NUM_SLOTS + 1);
  localparam int MW = (NUM_SLOTS < 8) ? NUM_SLOTS : 8;

  ptrs_state_t           state_r, state_nxt;
  logic [TIME_WIDTH-1:0] tick_count_r, tick_count_nxt;
  logic [UW-1:0]         used_count_r, used_count_nxt;
  logic                  err_r, err_nxt;
  logic [NUM_SLOTS-1:0]  res_mask_r;
  logic                  out_valid_r;
  ptrs_out_t             out_data_r;

  ptrs_cmd_t             launch_r, launch_nxt;
  logic [TIME_WIDTH-1:0] launch_time_r;
  logic [UW-1:0]         launch_used_r;

  ptrs_cmd_t             cmd_chain  [0:NUM_SLOTS];
  logic [TIME_WIDTH-1:0] time_chain [0:NUM_SLOTS];
  logic [UW-1:0]         used_chain [0:NUM_SLOTS];
  logic [NUM_SLOTS-1:0]  mask_chain [0:NUM_SLOTS];

  logic in_fire;
  logic chain_done;
  logic out_free;

  assign in_fire    = in_valid & in_ready;
  assign chain_done = cmd_chain[NUM_SLOTS].valid;
  assign out_free   = !out_valid_r || out_ready;

  // Decode of the accepted beat into a slot command.
  always_comb begin
    launch_nxt.valid    = in_fire;
    launch_nxt.op       = OP_NONE;
    launch_nxt.task_id  = in_data.task_id;
    launch_nxt.interval = in_data.interval;
    launch_nxt.one_shot = in_data.one_shot;
    tick_count_nxt      = tick_count_r;
    used_count_nxt      = used_count_r;
    err_nxt             = 1'b0;
    unique case (in_data.kind)
      KIND_ATTACH: begin
        if (used_count_r < UW'(NUM_SLOTS)) begin
          launch_nxt.op  = OP_ATTACH;
          used_count_nxt = used_count_r + UW'(1);
        end else begin
          err_nxt = 1'b1;
        end
      end
      KIND_TICK: begin
        launch_nxt.op  = OP_TICK;
        tick_count_nxt = tick_count_r + TIME_WIDTH'(1);
      end
      KIND_MSG: begin
        if (!in_data.msg_to_task && in_data.msg_source == 8'd0 &&
            in_data.msg_destination[7:1] == 7'd0) begin
          launch_nxt.op       = OP_MSG;
          launch_nxt.task_id  = in_data.msg_destination;
          launch_nxt.interval = in_data.msg_data;
        end
      end
      default: ;
    endcase
  end

  // Next state.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: if (in_fire) state_nxt = ST_RUN;
      ST_RUN:  if (chain_done) state_nxt = ST_HOLD;
      ST_HOLD: if (out_free) state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Outputs of the state machine.
  always_comb begin
    in_ready = 1'b0;
    unique case (state_r)
      ST_IDLE: in_ready = 1'b1;
      ST_RUN,
      ST_HOLD: in_ready = 1'b0;
      default: in_ready = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r        <= ST_IDLE;
      tick_count_r   <= '0;
      used_count_r   <= '0;
      launch_r       <= '0;
      out_valid_r    <= 1'b0;
    end else begin
      state_r        <= state_nxt;
      launch_r       <= launch_nxt;
      if (in_fire) begin
        tick_count_r <= tick_count_nxt;
        used_count_r <= used_count_nxt;
      end
      if (state_r == ST_HOLD && out_free) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    launch_time_r     <= tick_count_nxt;
    launch_used_r     <= used_count_r;
    if (in_fire) begin
      err_r <= err_nxt;
    end
    if (state_r == ST_RUN && chain_done) begin
      res_mask_r <= mask_chain[NUM_SLOTS];
    end
    if (state_r == ST_HOLD && out_free) begin
      out_data_r.release_mask <= 8'(res_mask_r[MW-1:0]);
      out_data_r.attach_error <= err_r;
      out_data_r.slots_used   <= 4'(used_count_r);
    end
  end

  assign cmd_chain[0]  = launch_r;
  assign time_chain[0] = launch_time_r;
  assign used_chain[0] = launch_used_r;
  assign mask_chain[0] = '0;

  for (genvar i = 0; i < NUM_SLOTS; i++) begin : g_slot
    ptrs_cell #(
      .NUM_SLOTS  (NUM_SLOTS),
      .TIME_WIDTH (TIME_WIDTH),
      .IDX        (i)
    ) u_cell (
      .clk    (clk),
      .rst_n  (rst_n),
      .cmd_i  (cmd_chain[i]),
      .time_i (time_chain[i]),
      .used_i (used_chain[i]),
      .mask_i (mask_chain[i]),
      .cmd_o  (cmd_chain[i+1]),
      .time_o (time_chain[i+1]),
      .used_o (used_chain[i+1]),
      .mask_o (mask_chain[i+1])
    );
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  a_used_bound: assert property (@(posedge clk) disable iff (!rst_n)
    used_count_r <= UW'(NUM_SLOTS))
    else $error("slot count beyond table size");

  a_launch: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire |=> launch_r.valid && state_r == ST_RUN)
    else $error("accepted beat not launched into the chain");

  a_idle_chain: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_IDLE |-> !chain_done && !launch_r.valid)
    else $error("chain busy while idle");

  a_collect: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_RUN && chain_done |=> state_r == ST_HOLD)
    else $error("chain result not collected");

endmodule

### sim/tb.sv
// Self-checking testbench for periodic_task_release_scheduler: attach, tick and message beats
// are checked against a cycle-free model of the slot table, with random sender bursts and
// receiver stalls. Depends on ptrs_pkg and the scheduler RTL.
module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import ptrs_pkg::*;

  localparam logic [1:0] KIND_UNUSED  = 2'd3;
  localparam int         RANDOM_BEATS = 400;
  localparam int         QUIET_LIMIT  = 4000;
  localparam int         DRAIN_CYCLES = 40;

  typedef enum logic [1:0] {
    RX_OPEN,
    RX_COIN,
    RX_SPARSE,
    RX_PATTERN
  } rx_mode_t;

  // Mirror of the slot table; every accepted beat yields exactly one result.
  class release_table;
    logic [31:0] now_tick;
    logic [3:0]  attached;
    logic [7:0]  slot_owner  [PTRS_NUM_SLOTS];
    logic [31:0] slot_period [PTRS_NUM_SLOTS];
    logic [31:0] slot_last   [PTRS_NUM_SLOTS];
    logic [31:0] slot_seen   [PTRS_NUM_SLOTS];
    bit          slot_single [PTRS_NUM_SLOTS];
    bit          slot_spent  [PTRS_NUM_SLOTS];
    ptrs_out_t   pending_results[$];
    int          errors;

    function new();
      now_tick = '0;
      attached = '0;
      errors   = 0;
      for (int s = 0; s < PTRS_NUM_SLOTS; s++) begin
        slot_owner[s]  = '0;
        slot_period[s] = '0;
        slot_last[s]   = '0;
        slot_seen[s]   = '0;
        slot_single[s] = 1'b0;
        slot_spent[s]  = 1'b0;
      end
    endfunction

    function void take_beat(ptrs_in_t b);
      ptrs_out_t r;
      bit        fire;
      int        slot;
      r = '0;
      case (b.kind)
        KIND_ATTACH: begin
          if (attached < PTRS_NUM_SLOTS) begin
            slot              = attached;
            slot_owner[slot]  = b.task_id;
            slot_period[slot] = b.interval;
            slot_single[slot] = b.one_shot;
            slot_last[slot]   = '0;
            slot_spent[slot]  = 1'b0;
            attached          = attached + 4'd1;
          end else begin
            r.attach_error = 1'b1;
          end
        end
        KIND_TICK: begin
          now_tick = now_tick + 32'd1;
          for (int s = 0; s < attached; s++) begin
            fire = 1'b0;
            if (slot_period[s] == '0) begin
              fire = 1'b1;
            end else begin
              slot_seen[s] = now_tick;
              if (32'(now_tick - slot_last[s]) == slot_period[s]) begin
                slot_last[s] = now_tick;
                fire         = 1'b1;
              end
            end
            // A one-shot slot keeps its timing but releases only once.
            if (fire && slot_single[s]) begin
              if (slot_spent[s]) fire = 1'b0;
              else slot_spent[s] = 1'b1;
            end
            if (fire && s < 8) r.release_mask[s] = 1'b1;
          end
        end
        KIND_MSG: begin
          if (!b.msg_to_task && b.msg_source == '0 && b.msg_destination <= 8'd1) begin
            for (int s = 0; s < attached; s++) begin
              if (slot_owner[s] == b.msg_destination) begin
                slot_period[s] = b.msg_data;
                slot_last[s]   = slot_seen[s];
              end
            end
          end
        end
        default: begin
        end
      endcase
      r.slots_used = attached;
      pending_results.push_back(r);
    endfunction

    function void match_result(ptrs_out_t got);
      ptrs_out_t want;
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected result mask %h error %b used %0d", $time,
                 got.release_mask, got.attach_error, got.slots_used);
        errors++;
        return;
      end
      want = pending_results.pop_front();
      if (got.release_mask !== want.release_mask) begin
        $display("%0t: release_mask expected %h actual %h", $time,
                 want.release_mask, got.release_mask);
        errors++;
      end
      if (got.attach_error !== want.attach_error) begin
        $display("%0t: attach_error expected %b actual %b", $time,
                 want.attach_error, got.attach_error);
        errors++;
      end
      if (got.slots_used !== want.slots_used) begin
        $display("%0t: slots_used expected %0d actual %0d", $time,
                 want.slots_used, got.slots_used);
        errors++;
      end
    endfunction
  endclass

  logic      clk       = 1'b0;
  logic      rst_n     = 1'b0;
  logic      in_valid  = 1'b0;
  logic      in_ready;
  ptrs_in_t  in_data   = '0;
  logic      out_valid;
  logic      out_ready = 1'b0;
  ptrs_out_t out_data;

  release_table book = new();
  int       burst_left = 0;
  rx_mode_t rx_mode    = RX_OPEN;
  int       rx_cycle   = 0;
  logic [15:0] rx_pattern = 16'hFFFF;

  periodic_task_release_scheduler dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Receiver: draws a new stall style and pattern at random at regular intervals.
  always @(posedge clk) begin
    rx_cycle = rx_cycle + 1;
    if (rx_cycle % 48 == 0) begin
      rx_mode    = rx_mode_t'($urandom_range(0, 3));
      rx_pattern = 16'($urandom);
    end
    case (rx_mode)
      RX_OPEN:   out_ready <= 1'b1;
      RX_COIN:   out_ready <= 1'($urandom_range(0, 1));
      RX_SPARSE: out_ready <= ($urandom_range(0, 7) == 0);
      default: begin
        rx_pattern = {rx_pattern[14:0], rx_pattern[15]};
        out_ready <= rx_pattern[15];
      end
    endcase
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && in_ready) book.take_beat(in_data);
      if (out_valid && out_ready) book.match_result(out_data);
    end
  end

  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < QUIET_LIMIT) begin
      @(posedge clk);
      if ((in_valid && in_ready) || (out_valid && out_ready)) quiet = 0;
      else quiet++;
    end
    $display("tb: failure");
    $finish;
  end

  function automatic ptrs_in_t make_beat(logic [1:0] kind, logic [7:0] task_id,
                                         logic [31:0] interval, logic one_shot,
                                         logic [7:0] src, logic [7:0] dst,
                                         logic to_task, logic [31:0] data);
    ptrs_in_t b;
    b.kind            = kind;
    b.task_id         = task_id;
    b.interval        = interval;
    b.one_shot        = one_shot;
    b.msg_source      = src;
    b.msg_destination = dst;
    b.msg_to_task     = to_task;
    b.msg_data        = data;
    return b;
  endfunction

  // Mostly ticks and well-formed retiming messages for tasks 0 and 1, which own
  // most slots; the rest are attaches to the full table and ignored beats.
  function automatic ptrs_in_t random_beat();
    ptrs_in_t b;
    int       pick;
    b.kind            = KIND_TICK;
    b.task_id         = 8'($urandom_range(0, 255));
    b.interval        = $urandom;
    b.one_shot        = 1'($urandom_range(0, 1));
    b.msg_source      = 8'($urandom_range(0, 255));
    b.msg_destination = 8'($urandom_range(0, 255));
    b.msg_to_task     = 1'($urandom_range(0, 1));
    b.msg_data        = $urandom;
    pick = $urandom_range(0, 99);
    if (pick < 45) begin
      b.kind = KIND_TICK;
    end else if (pick < 72) begin
      b.kind            = KIND_MSG;
      b.msg_source      = '0;
      b.msg_to_task     = 1'b0;
      b.msg_destination = 8'($urandom_range(0, 1));
      if ($urandom_range(0, 4) != 0) b.msg_data = $urandom_range(0, 9);
    end else if (pick < 82) begin
      b.kind = KIND_ATTACH;
    end else if (pick < 94) begin
      b.kind = KIND_MSG;
      case ($urandom_range(0, 2))
        0:       b.msg_source = 8'($urandom_range(1, 255));
        1:       b.msg_destination = 8'($urandom_range(2, 255));
        default: b.msg_to_task = 1'b1;
      endcase
    end else begin
      b.kind = KIND_UNUSED;
    end
    return b;
  endfunction

  // Sender works in bursts; a gap drops valid before the next burst starts.
  task automatic push_beat(input ptrs_in_t b);
    if (burst_left == 0) begin
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60)
                                               : $urandom_range(1, 8);
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 15)) @(posedge clk);
    end
    burst_left--;
    in_valid <= 1'b1;
    in_data  <= b;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  initial begin : stimulus
    ptrs_in_t b;
    int       counted;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    push_beat(make_beat(KIND_TICK, 8'h00, 32'h0, 1'b0, 8'h00, 8'h00, 1'b0, 32'h0));
    push_beat(make_beat(KIND_ATTACH, 8'h00, 32'h0, 1'b0, 8'h00, 8'h00, 1'b0, 32'h0));
    push_beat(make_beat(KIND_ATTACH, 8'h01, 32'h0, 1'b1, 8'h00, 8'h00, 1'b0, 32'h0));
    push_beat(make_beat(KIND_TICK, 8'h00, 32'h0, 1'b0, 8'h00, 8'h00, 1'b0, 32'h0));
    push_beat(make_beat(KIND_TICK, 8'hFF, 32'hFFFF_FFFF, 1'b1, 8'hFF, 8'hFF, 1'b1,
                        32'hFFFF_FFFF));
    // An all-ones interval can never be reached by the counter distance soon.
    push_beat(make_beat(KIND_ATTACH, 8'hFF, 32'hFFFF_FFFF, 1'b0, 8'h00, 8'h00, 1'b0, 32'h0));
    push_beat(make_beat(KIND_ATTACH, 8'h00, 32'd3, 1'b1, 8'h00, 8'h00, 1'b0, 32'h0));
    push_beat(make_beat(KIND_ATTACH, 8'h01, 32'd2, 1'b0, 8'h00, 8'h00, 1'b0, 32'h0));
    push_beat(make_beat(KIND_MSG, 8'h00, 32'h0, 1'b0, 8'h00, 8'h00, 1'b0, 32'd2));
    push_beat(make_beat(KIND_TICK, 8'h00, 32'h0, 1'b0, 8'h00, 8'h00, 1'b0, 32'h0));
    push_beat(make_beat(KIND_TICK, 8'h00, 32'h0, 1'b0, 8'h00, 8'h00, 1'b0, 32'h0));
    push_beat(make_beat(KIND_MSG, 8'h00, 32'h0, 1'b0, 8'h80, 8'h00, 1'b0, 32'd1));
    push_beat(make_beat(KIND_MSG, 8'h00, 32'h0, 1'b0, 8'h00, 8'h02, 1'b0, 32'd1));
    push_beat(make_beat(KIND_MSG, 8'h00, 32'h0, 1'b0, 8'h00, 8'h01, 1'b1, 32'd1));
    push_beat(make_beat(KIND_UNUSED, 8'hFF, 32'd1, 1'b1, 8'h00, 8'h00, 1'b0, 32'h0));
    push_beat(make_beat(KIND_ATTACH, 8'h5A, 32'd1, 1'b1, 8'h00, 8'h00, 1'b0, 32'h0));
    push_beat(make_beat(KIND_ATTACH, 8'h01, 32'd4, 1'b0, 8'h00, 8'h00, 1'b0, 32'h0));
    push_beat(make_beat(KIND_ATTACH, 8'h00, 32'd1, 1'b0, 8'h00, 8'h00, 1'b0, 32'h0));
    // The table is full now, so this attach must be refused.
    push_beat(make_beat(KIND_ATTACH, 8'hFF, 32'hFFFF_FFFF, 1'b1, 8'hFF, 8'hFF, 1'b1,
                        32'hFFFF_FFFF));
    push_beat(make_beat(KIND_MSG, 8'h00, 32'h0, 1'b0, 8'h00, 8'h01, 1'b0, 32'hFFFF_FFFF));
    push_beat(make_beat(KIND_TICK, 8'h00, 32'h0, 1'b0, 8'h00, 8'h00, 1'b0, 32'h0));
    push_beat(make_beat(KIND_TICK, 8'h00, 32'h0, 1'b0, 8'h00, 8'h00, 1'b0, 32'h0));
    push_beat(make_beat(KIND_MSG, 8'h00, 32'h0, 1'b0, 8'h00, 8'h01, 1'b0, 32'h0));
    push_beat(make_beat(KIND_TICK, 8'h00, 32'h0, 1'b0, 8'h00, 8'h00, 1'b0, 32'h0));
    push_beat(make_beat(KIND_TICK, 8'h00, 32'h0, 1'b0, 8'h00, 8'h00, 1'b0, 32'h0));

    counted = 0;
    while (counted < RANDOM_BEATS) begin
      b = random_beat();
      push_beat(b);
      counted++;
    end
    in_valid <= 1'b0;

    // Let the monitor record the last accepted beat before waiting on it.
    @(posedge clk);
    while (book.pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (book.errors == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
